/* hw/rtl/waypoint_mission_with_dead_reckoning_unit_assert.svh */
// ----------------------------------------------------------------------------
// waypoint mission unit: assertion macros
// shared forms for the concurrent checks of the mission block
// ----------------------------------------------------------------------------
`ifndef WAYPOINT_MISSION_WITH_DEAD_RECKONING_UNIT_ASSERT_SVH
`define WAYPOINT_MISSION_WITH_DEAD_RECKONING_UNIT_ASSERT_SVH

// checked on every edge outside reset
`define WMDR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define WMDR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hw/rtl/wmdr_pkg.sv */
// ----------------------------------------------------------------------------
// wmdr_pkg
// constants, types and helpers of the waypoint mission odometry unit
// ----------------------------------------------------------------------------
package wmdr_pkg;

  localparam int CordicStepsDef = 16;

  // register map indexes
  localparam logic [2:0] RegForwardSpeed   = 3'd0;
  localparam logic [2:0] RegXGoal          = 3'd1;
  localparam logic [2:0] RegYGoal          = 3'd2;
  localparam logic [2:0] RegTurnRate       = 3'd3;
  localparam logic [2:0] RegTurnAngleLimit = 3'd4;

  localparam logic signed [31:0] ForwardSpeedRst   = 32'sd16384;
  localparam logic signed [31:0] XGoalRst          = 32'sd163840;
  localparam logic signed [31:0] YGoalRst          = 32'sd327680;
  localparam logic signed [31:0] TurnRateRst       = 32'sd13107;
  localparam logic signed [31:0] TurnAngleLimitRst = 32'sd100433;

  // mission phases
  localparam logic [1:0] PhDriveX = 2'd0;
  localparam logic [1:0] PhTurn   = 2'd1;
  localparam logic [1:0] PhDriveY = 2'd2;
  localparam logic [1:0] PhStop   = 2'd3;

  localparam logic signed [34:0] GainQ16 = 35'sd144179;
  localparam logic signed [31:0] SlowQ16 = 32'sd6554;
  localparam logic signed [31:0] TinyQ16 = 32'sd7;

  localparam logic signed [35:0] PiQ30     = 36'sd3373259426;
  localparam logic signed [35:0] TwoPiQ30  = 36'sd6746518852;
  localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [33:0] CordicKQ30 = 34'sd652032875;

  typedef struct packed {
    logic               start;
    logic signed [31:0] angle;
  } trig_req_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] dividend;
    logic signed [45:0] divisor;
  } div_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    if (v > 72'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (v < -72'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // round to nearest, ties upward
  function automatic logic signed [69:0] rnd16(input logic signed [69:0] v);
    return (v + 70'sd32768) >>> 16;
  endfunction

  function automatic logic signed [69:0] rnd30(input logic signed [69:0] v);
    return (v + 70'sd536870912) >>> 30;
  endfunction

  function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0:  return 36'sd843314857;
      5'd1:  return 36'sd497837830;
      5'd2:  return 36'sd263043837;
      5'd3:  return 36'sd133525159;
      5'd4:  return 36'sd67021687;
      5'd5:  return 36'sd33543516;
      5'd6:  return 36'sd16775851;
      5'd7:  return 36'sd8388437;
      5'd8:  return 36'sd4194283;
      5'd9:  return 36'sd2097149;
      5'd10: return 36'sd1048576;
      5'd11: return 36'sd524288;
      5'd12: return 36'sd262144;
      5'd13: return 36'sd131072;
      5'd14: return 36'sd65536;
      5'd15: return 36'sd32768;
      5'd16: return 36'sd16384;
      5'd17: return 36'sd8192;
      5'd18: return 36'sd4096;
      5'd19: return 36'sd2048;
      5'd20: return 36'sd1024;
      5'd21: return 36'sd512;
      5'd22: return 36'sd256;
      5'd23: return 36'sd128;
      5'd24: return 36'sd64;
      5'd25: return 36'sd32;
      5'd26: return 36'sd16;
      5'd27: return 36'sd8;
      5'd28: return 36'sd4;
      5'd29: return 36'sd2;
      5'd30: return 36'sd1;
      default: return 36'sd0;
    endcase
  endfunction

endpackage

/* hw/rtl/waypoint_mission_with_dead_reckoning_unit.sv */
// ----------------------------------------------------------------------------
// waypoint_mission_with_dead_reckoning_unit
// four-phase waypoint mission with measured and commanded pose odometry
// ----------------------------------------------------------------------------
// channel  dir  handshake                   payload
// s_axis   in   s_axis_tvalid/tready        speeds x y, yaw rate, elapsed time
// m_axis   out  m_axis_tvalid/tready        command, phase, both poses; tlast
// apb      in   psel/penable/pwrite/pready  five 32-bit mission registers
//
// each sample runs on a shared 35x35 multiplier, a cordic unit and a 64-step
// divider that is used twice for each arc integration.
// the block takes no sample until the last result of the previous one is
// taken; a stalled output simply holds. reset clears poses, phase and
// registers to their defaults, no clearing pass.
// ----------------------------------------------------------------------------
module waypoint_mission_with_dead_reckoning_unit import wmdr_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // meas_speed_x, meas_speed_y, meas_yaw_rate, elapsed_time, pad
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // drive_speed, drive_rate, mission_phase, meas_pose_x, meas_pose_y,
  // meas_heading, cmd_pose_x, cmd_pose_y, cmd_heading, pad
  output logic [263:0] m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic [4:0] StIdle = 5'd0;
  localparam logic [4:0] StPdx  = 5'd1;
  localparam logic [4:0] StPdy  = 5'd2;
  localparam logic [4:0] StPdth = 5'd3;
  localparam logic [4:0] StPset = 5'd4;
  localparam logic [4:0] StIwt  = 5'd5;
  localparam logic [4:0] StIth  = 5'd6;
  localparam logic [4:0] StIs0  = 5'd7;
  localparam logic [4:0] StLx1  = 5'd8;
  localparam logic [4:0] StLx2  = 5'd9;
  localparam logic [4:0] StLx3  = 5'd10;
  localparam logic [4:0] StLy2  = 5'd11;
  localparam logic [4:0] StLy3  = 5'd12;
  localparam logic [4:0] StIs1  = 5'd13;
  localparam logic [4:0] StAx1  = 5'd14;
  localparam logic [4:0] StAx2  = 5'd15;
  localparam logic [4:0] StAx3  = 5'd16;
  localparam logic [4:0] StAy2  = 5'd17;
  localparam logic [4:0] StAy3  = 5'd18;
  localparam logic [4:0] StIend = 5'd19;
  localparam logic [4:0] StOut0 = 5'd20;
  localparam logic [4:0] StOut1 = 5'd21;

  logic [4:0] state_q;

  logic signed [31:0] fwd_q, xgoal_q, ygoal_q, trate_q, tlim_q;
  logic signed [31:0] meas_x_q, meas_y_q, meas_th_q, cmd_x_q, cmd_y_q, cmd_th_q;
  logic signed [31:0] prev_q, sum_q, wz_q, iv_q, iw_q, cv_q, cw_q, th1_q;
  logic signed [31:0] pub_v_q, pub_w_q;
  logic [1:0]         phase_q, pub_p_q;
  logic [30:0]        t_q;
  logic               two_q, sel_cmd_q;
  logic signed [39:0] mdx_q, mdy_q;
  logic signed [33:0] s0_q, c0_q, s1_q, c1_q;

  logic signed [34:0] mul_a, mul_b;
  logic signed [69:0] mul_p_q, p_r16, p_r30;

  logic signed [31:0] cur_x, cur_y, cur_th;
  logic signed [31:0] pset_v, pset_w, pset_cv, pset_cw, in_sum;
  logic               pset_done, cfg_wr, in_acc, out_acc;
  logic signed [32:0] dx, dy, dth;

  trig_req_t          trig_req;
  logic               trig_done;
  logic signed [33:0] trig_sin, trig_cos;
  div_req_t           div_req;
  logic               div_done;
  logic signed [63:0] div_quot;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_comb begin
    case (paddr[4:2])
      RegForwardSpeed:   prdata = fwd_q;
      RegXGoal:          prdata = xgoal_q;
      RegYGoal:          prdata = ygoal_q;
      RegTurnRate:       prdata = trate_q;
      RegTurnAngleLimit: prdata = tlim_q;
      default:           prdata = '0;
    endcase
  end

  assign cur_x  = sel_cmd_q ? cmd_x_q : meas_x_q;
  assign cur_y  = sel_cmd_q ? cmd_y_q : meas_y_q;
  assign cur_th = sel_cmd_q ? cmd_th_q : meas_th_q;

  assign dx  = 33'(cmd_x_q) - 33'(meas_x_q);
  assign dy  = 33'(cmd_y_q) - 33'(meas_y_q);
  assign dth = 33'(cmd_th_q) - 33'(meas_th_q);

  assign in_sum = sat32(72'($signed(s_axis_tdata[31:0])) + 72'($signed(s_axis_tdata[63:32])));

  assign p_r16 = rnd16(mul_p_q);
  assign p_r30 = rnd30(mul_p_q);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StPdx:  begin mul_a = 35'(dx);  mul_b = GainQ16; end
      StPdy:  begin mul_a = 35'(dy);  mul_b = GainQ16; end
      StPdth: begin mul_a = 35'(dth); mul_b = GainQ16; end
      StIwt:  begin mul_a = 35'(iw_q); mul_b = $signed({4'b0, t_q}); end
      StLx1:  begin mul_a = 35'(iv_q); mul_b = 35'(c0_q); end
      StLx2, StLy2: begin mul_a = p_r30[34:0]; mul_b = $signed({4'b0, t_q}); end
      StLx3:  begin mul_a = 35'(iv_q); mul_b = 35'(s0_q); end
      StAx1:  begin mul_a = 35'(iv_q); mul_b = 35'(s1_q) - 35'(s0_q); end
      StAx3:  begin mul_a = 35'(iv_q); mul_b = 35'(c0_q) - 35'(c1_q); end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_p_q <= mul_a * mul_b;
  end

  // command and next-phase decision from the state before the sample
  always_comb begin
    pset_v    = '0;
    pset_w    = '0;
    pset_cv   = '0;
    pset_cw   = '0;
    pset_done = 1'b0;
    case (phase_q)
      PhDriveX, PhDriveY: begin
        pset_v    = sat32(72'(fwd_q) + 72'(mdx_q) + 72'(mdy_q));
        pset_w    = sat32(72'(p_r16));
        pset_cv   = (prev_q <= SlowQ16) ? '0 : fwd_q;
        pset_done = (phase_q == PhDriveX) ? (cmd_x_q >= xgoal_q) : (cmd_y_q >= ygoal_q);
      end
      PhTurn: begin
        pset_w    = sat32(72'(trate_q) + 72'(p_r16));
        pset_cw   = (meas_th_q <= TinyQ16) ? '0 : trate_q;
        pset_done = cmd_th_q >= tlim_q;
      end
      default: ;
    endcase
  end

  assign trig_req.start = (state_q == StIwt) ||
                          (state_q == StIs0 && trig_done && iw_q != 32'sd0);
  assign trig_req.angle = (state_q == StIwt) ? cur_th : th1_q;

  assign div_req.start    = (state_q == StAx2) || (state_q == StAy2);
  assign div_req.dividend = mul_p_q[63:0];
  assign div_req.divisor  = {iw_q, 14'b0};

  wmdr_sincos #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_sincos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (trig_req),
    .done_o (trig_done),
    .sin_o  (trig_sin),
    .cos_o  (trig_cos)
  );

  wmdr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      fwd_q     <= ForwardSpeedRst;
      xgoal_q   <= XGoalRst;
      ygoal_q   <= YGoalRst;
      trate_q   <= TurnRateRst;
      tlim_q    <= TurnAngleLimitRst;
      meas_x_q  <= '0;
      meas_y_q  <= '0;
      meas_th_q <= '0;
      cmd_x_q   <= '0;
      cmd_y_q   <= '0;
      cmd_th_q  <= '0;
      phase_q   <= PhDriveX;
      prev_q    <= '0;
      two_q     <= 1'b0;
      sel_cmd_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (paddr[4:2])
          RegForwardSpeed:   fwd_q   <= pwdata;
          RegXGoal:          xgoal_q <= pwdata;
          RegYGoal:          ygoal_q <= pwdata;
          RegTurnRate:       trate_q <= pwdata;
          RegTurnAngleLimit: tlim_q  <= pwdata;
          default: ;
        endcase
      end
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            state_q <= StPdx;
          end
        end
        StPdx:  state_q <= StPdy;
        StPdy:  state_q <= StPdth;
        StPdth: state_q <= StPset;
        StPset: begin
          two_q     <= pset_done;
          sel_cmd_q <= 1'b0;
          prev_q    <= sum_q;
          if (pset_done) begin
            phase_q <= phase_q + 2'd1;
          end
          state_q <= StIwt;
        end
        StIwt: state_q <= StIth;
        StIth: state_q <= StIs0;
        StIs0: begin
          if (trig_done) begin
            state_q <= (iw_q == 32'sd0) ? StLx1 : StIs1;
          end
        end
        StLx1: state_q <= StLx2;
        StLx2: state_q <= StLx3;
        StLx3: begin
          if (sel_cmd_q) cmd_x_q <= sat32(72'(cur_x) + 72'(p_r16));
          else           meas_x_q <= sat32(72'(cur_x) + 72'(p_r16));
          state_q <= StLy2;
        end
        StLy2: state_q <= StLy3;
        StLy3: begin
          if (sel_cmd_q) begin
            cmd_y_q  <= sat32(72'(cur_y) + 72'(p_r16));
            cmd_th_q <= th1_q;
          end else begin
            meas_y_q  <= sat32(72'(cur_y) + 72'(p_r16));
            meas_th_q <= th1_q;
          end
          state_q <= StIend;
        end
        StIs1: begin
          if (trig_done) begin
            state_q <= StAx1;
          end
        end
        StAx1: state_q <= StAx2;
        StAx2: state_q <= StAx3;
        StAx3: begin
          if (div_done) begin
            if (sel_cmd_q) cmd_x_q <= sat32(72'(cur_x) + 72'(div_quot));
            else           meas_x_q <= sat32(72'(cur_x) + 72'(div_quot));
            state_q <= StAy2;
          end
        end
        StAy2: state_q <= StAy3;
        StAy3: begin
          if (div_done) begin
            if (sel_cmd_q) begin
              cmd_y_q  <= sat32(72'(cur_y) + 72'(div_quot));
              cmd_th_q <= th1_q;
            end else begin
              meas_y_q  <= sat32(72'(cur_y) + 72'(div_quot));
              meas_th_q <= th1_q;
            end
            state_q <= StIend;
          end
        end
        StIend: begin
          // commanded pose moves only once the measured pose is positive somewhere
          if (!sel_cmd_q && (meas_x_q > 0 || meas_y_q > 0 || meas_th_q > 0)) begin
            sel_cmd_q <= 1'b1;
            state_q   <= StIwt;
          end else begin
            state_q <= StOut0;
          end
        end
        StOut0: begin
          if (out_acc) begin
            state_q <= two_q ? StOut1 : StIdle;
          end
        end
        StOut1: begin
          if (out_acc) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          sum_q <= in_sum;
          wz_q  <= $signed(s_axis_tdata[95:64]);
          t_q   <= s_axis_tdata[126:96];
        end
      end
      StPdy:  mdx_q <= p_r16[39:0];
      StPdth: mdy_q <= p_r16[39:0];
      StPset: begin
        pub_v_q <= pset_v;
        pub_w_q <= pset_w;
        pub_p_q <= phase_q;
        cv_q    <= pset_done ? '0 : pset_cv;
        cw_q    <= pset_done ? '0 : pset_cw;
        iv_q    <= sum_q;
        iw_q    <= wz_q;
      end
      StIth: th1_q <= sat32(72'(cur_th) + 72'(p_r16));
      StIs0: begin
        if (trig_done) begin
          s0_q <= trig_sin;
          c0_q <= trig_cos;
        end
      end
      StIs1: begin
        if (trig_done) begin
          s1_q <= trig_sin;
          c1_q <= trig_cos;
        end
      end
      StIend: begin
        iv_q <= cv_q;
        iw_q <= cw_q;
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StOut0) || (state_q == StOut1);
  assign m_axis_tlast  = (state_q == StOut1) || !two_q;

  always_comb begin
    logic signed [31:0] ov, ow;
    logic [1:0]         op;
    ov = '0;
    ow = '0;
    op = phase_q;
    if (state_q == StOut0) begin
      ov = pub_v_q;
      ow = pub_w_q;
      op = pub_p_q;
    end
    m_axis_tdata = {6'b0, cmd_th_q, cmd_y_q, cmd_x_q, meas_th_q, meas_y_q, meas_x_q,
                    op, ow, ov};
  end

  `include "waypoint_mission_with_dead_reckoning_unit_assert.svh"

  `WMDR_ASSERT(a_no_overlap, !(s_axis_tready && m_axis_tvalid), "request taken while a result is pending")
  `WMDR_ASSERT(a_busy_after_take, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "ready held after a request was taken")
  `WMDR_ASSERT(a_idle_after_last, (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready, "not idle after the final result")
  `WMDR_ASSERT(a_phase_step, (phase_q != $past(phase_q)) |-> (phase_q == $past(phase_q) + 2'd1), "mission phase skipped or went back")

endmodule

/* hw/rtl/wmdr_div.sv */
// ----------------------------------------------------------------------------
// wmdr_div
// radix-2 restoring divider, one quotient bit a cycle, truncating toward zero
// ----------------------------------------------------------------------------
module wmdr_div import wmdr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  div_req_t           req_i,
  output logic               done_o,
  output logic signed [63:0] quot_o
);

  logic        busy_q, done_q, neg_q;
  logic [5:0]  cnt_q;
  logic [45:0] rem_q, den_q;
  logic [63:0] dvd_q;
  logic [46:0] trial;
  logic        ge;

  assign trial = {rem_q, dvd_q[63]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvd_q <= req_i.dividend[63] ? 64'(-req_i.dividend) : 64'(req_i.dividend);
      den_q <= req_i.divisor[45] ? 46'(-req_i.divisor) : 46'(req_i.divisor);
      neg_q <= req_i.dividend[63] ^ req_i.divisor[45];
    end else if (busy_q) begin
      rem_q <= ge ? 46'(trial - {1'b0, den_q}) : trial[45:0];
      dvd_q <= {dvd_q[62:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(dvd_q) : $signed(dvd_q);

endmodule

/* hw/rtl/wmdr_sincos.sv */
// ----------------------------------------------------------------------------
// wmdr_sincos
// angle reduction modulo two pi by shift-subtract, then rotation-mode cordic
// ----------------------------------------------------------------------------
module wmdr_sincos import wmdr_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  trig_req_t          req_i,
  output logic               done_o,
  output logic signed [33:0] sin_o,
  output logic signed [33:0] cos_o
);

  localparam logic [2:0] ScIdle  = 3'd0;
  localparam logic [2:0] ScMod   = 3'd1;
  localparam logic [2:0] ScFold1 = 3'd2;
  localparam logic [2:0] ScFold2 = 3'd3;
  localparam logic [2:0] ScRot   = 3'd4;

  localparam logic [4:0] LastStep = 5'(CORDIC_STEPS - 1);

  logic [2:0]         state_q;
  logic               done_q, neg_q, flip_q;
  logic [3:0]         k_q;
  logic [4:0]         i_q;
  logic [45:0]        rem_q, sub;
  logic signed [45:0] a_full;
  logic signed [35:0] r_q, atan_i;
  logic signed [33:0] x_q, y_q;

  assign a_full = {req_i.angle, 14'b0};
  assign sub    = 46'(TwoPiQ30) << k_q;
  assign atan_i = atan_q30(i_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ScIdle;
      done_q  <= 1'b0;
      k_q     <= '0;
      i_q     <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ScIdle: begin
          if (req_i.start) begin
            state_q <= ScMod;
            k_q     <= 4'd12;
          end
        end
        ScMod: begin
          k_q <= k_q - 4'd1;
          if (k_q == 4'd0) begin
            state_q <= ScFold1;
          end
        end
        ScFold1: state_q <= ScFold2;
        ScFold2: begin
          state_q <= ScRot;
          i_q     <= '0;
        end
        ScRot: begin
          i_q <= i_q + 5'd1;
          if (i_q == LastStep) begin
            state_q <= ScIdle;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= ScIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ScIdle: begin
        if (req_i.start) begin
          neg_q <= req_i.angle[31];
          rem_q <= req_i.angle[31] ? 46'(-a_full) : 46'(a_full);
        end
      end
      ScMod: begin
        if (rem_q >= sub) begin
          rem_q <= rem_q - sub;
        end
        // remainder keeps the sign of the angle
        if (k_q == 4'd0) begin
          r_q <= neg_q ? -$signed(36'(rem_q >= sub ? rem_q - sub : rem_q))
                       : $signed(36'(rem_q >= sub ? rem_q - sub : rem_q));
        end
      end
      ScFold1: begin
        if (r_q > PiQ30) begin
          r_q <= r_q - TwoPiQ30;
        end else if (r_q < -PiQ30) begin
          r_q <= r_q + TwoPiQ30;
        end
      end
      ScFold2: begin
        x_q    <= CordicKQ30;
        y_q    <= '0;
        flip_q <= 1'b0;
        if (r_q > HalfPiQ30) begin
          r_q    <= r_q - PiQ30;
          flip_q <= 1'b1;
        end else if (r_q < -HalfPiQ30) begin
          r_q    <= r_q + PiQ30;
          flip_q <= 1'b1;
        end
      end
      ScRot: begin
        if (r_q >= 0) begin
          x_q <= x_q - (y_q >>> i_q);
          y_q <= y_q + (x_q >>> i_q);
          r_q <= r_q - atan_i;
        end else begin
          x_q <= x_q + (y_q >>> i_q);
          y_q <= y_q - (x_q >>> i_q);
          r_q <= r_q + atan_i;
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign cos_o  = flip_q ? -x_q : x_q;
  assign sin_o  = flip_q ? -y_q : y_q;

endmodule
